FILE: rtl/core/stq_pkg.sv
package stq_pkg;

  // Operation codes carried on func.
  localparam logic [1:0] FUNC_ARM    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  // Result kinds.
  localparam logic KIND_CANCEL = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // Upper bound of expiry notices per tick.
  localparam int unsigned MAX_NOTICES = 16;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 31;
  localparam int unsigned SLOT_W  = 4;

  // One slot entry as held in the slot memory.
  typedef struct packed {
    logic [TIME_W-1:0]  expiry;
    logic [DELAY_W-1:0] reload;
    logic [TIME_W-1:0]  stamp;
  } stq_entry_t;

endpackage

FILE: rtl/core/stq_ram.sv
module stq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sorted_timer_queue_core.sv
// Operation: an arm needs no busy state; a cancel holds busy in S_CANCEL, and its reply
//   strobe is registered from that state. A tick holds busy for a due pass over all slots,
//   then one selection round per notice and a closing round, or S_FLUSH at MAX_NOTICES.
// Throughput: one item per busy period; the tick time is set by the slot memory read port,
//   which one compare unit walks once per pass; the receiver cannot stall results.
// Reset: rst_ni clears the tick count, stamp counter and active bits; slot memory is not reset.
module sorted_timer_queue_core
  import stq_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [DELAY_W-1:0] delay_i,
  input  logic [DELAY_W-1:0] reload_interval_i,
  output logic               result_valid_o,
  output logic               kind_o,
  output logic [SLOT_W-1:0]  slot_out_o,
  output logic               was_active_o,
  output logic [DELAY_W-1:0] remaining_o,
  output logic               last_o
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned NW = $clog2(MAX_NOTICES + 1);
  localparam logic [SW-1:0] IDX_LAST = SW'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CANCEL,
    S_DUE,
    S_DUE_END,
    S_SEL,
    S_SEL_END,
    S_PICK,
    S_FLUSH
  } state_e;

  state_e state_q;

  // Scan address and the check stage that sees the registered read data.
  logic [SW-1:0] idx_q;
  logic          chk_v_q;
  logic [SW-1:0] chk_idx_q;

  logic [NUM_SLOTS-1:0] active_q;
  logic [NUM_SLOTS-1:0] due_q;
  logic [TIME_W-1:0]    now_q;
  logic [TIME_W-1:0]    stamp_cnt_q;
  logic [SLOT_W-1:0]    slot_q;

  // Running best candidate of one selection round.
  logic               best_v_q;
  logic [SW-1:0]      best_idx_q;
  logic [TIME_W-1:0]  best_diff_q;
  logic [TIME_W-1:0]  best_stamp_q;
  logic [DELAY_W-1:0] best_reload_q;

  // A chosen slot waits here until the next round tells whether it is the last one.
  logic          pend_v_q;
  logic [SW-1:0] pend_idx_q;
  logic [NW-1:0] notice_cnt_q;

  logic               res_valid_q;
  logic               kind_q;
  logic [SLOT_W-1:0]  slot_out_q;
  logic               was_q;
  logic [DELAY_W-1:0] rem_q;
  logic               last_q;

  // Slot memory ports.
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  stq_entry_t    ram_wdata;
  logic [SW-1:0] ram_raddr;
  stq_entry_t    ram_rdata;

  logic              accept;
  logic              in_range_i;
  logic              in_range_q;
  logic [TIME_W-1:0] diff;
  logic              diff_le0;
  logic [TIME_W-1:0] stamp_diff;
  logic              better;
  logic              idx_at_last;
  logic              rearm;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && (state_q == S_IDLE);
  assign in_range_i  = (32'(slot_i) < NUM_SLOTS);
  assign in_range_q  = (32'(slot_q) < NUM_SLOTS);
  assign idx_at_last = (idx_q == IDX_LAST);
  assign rearm       = (state_q == S_PICK) && best_v_q && (best_reload_q != '0);

  // Shared compare unit: time left of the slot on the read port, and stamp order.
  assign diff       = ram_rdata.expiry - now_q;
  assign diff_le0   = diff[TIME_W-1] || (diff == '0);
  assign stamp_diff = ram_rdata.stamp - best_stamp_q;
  assign better     = !best_v_q
                   || ($signed(diff) < $signed(best_diff_q))
                   || ((diff == best_diff_q) && stamp_diff[TIME_W-1]);

  // Write port: a fresh arm from the input, or a reload re-arm of the picked slot.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx_q;
    ram_wdata = '{expiry: now_q + {1'b0, best_reload_q},
                  reload: best_reload_q,
                  stamp:  stamp_cnt_q};
    if (accept && (func_i == FUNC_ARM) && in_range_i) begin
      ram_we    = 1'b1;
      ram_waddr = SW'(slot_i);
      ram_wdata = '{expiry: now_q + {1'b0, delay_i},
                    reload: reload_interval_i,
                    stamp:  stamp_cnt_q};
    end else if (rearm) begin
      ram_we = 1'b1;
    end
  end

  // Read port: the addressed slot for a cancel, else the scan address.
  assign ram_raddr = (state_q == S_IDLE) ? SW'(slot_i) : idx_q;

  stq_ram #(
    .WIDTH($bits(stq_entry_t)),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      chk_v_q       <= 1'b0;
      chk_idx_q     <= '0;
      active_q      <= '0;
      due_q         <= '0;
      now_q         <= '0;
      stamp_cnt_q   <= '0;
      slot_q        <= '0;
      best_v_q      <= 1'b0;
      best_idx_q    <= '0;
      best_diff_q   <= '0;
      best_stamp_q  <= '0;
      best_reload_q <= '0;
      pend_v_q      <= 1'b0;
      pend_idx_q    <= '0;
      notice_cnt_q  <= '0;
      res_valid_q   <= 1'b0;
      kind_q        <= KIND_CANCEL;
      slot_out_q    <= '0;
      was_q         <= 1'b0;
      rem_q         <= '0;
      last_q        <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      chk_v_q     <= (state_q == S_DUE) || (state_q == S_SEL);
      chk_idx_q   <= idx_q;

      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            slot_q <= slot_i;
            if (func_i == FUNC_ARM) begin
              // Re-arming an active slot simply overwrites its entry.
              if (in_range_i) begin
                active_q[SW'(slot_i)] <= 1'b1;
                stamp_cnt_q           <= stamp_cnt_q + 1'b1;
              end
            end else if (func_i == FUNC_CANCEL) begin
              state_q <= S_CANCEL;
            end else if (func_i == FUNC_TICK) begin
              now_q        <= now_q + 1'b1;
              idx_q        <= '0;
              pend_v_q     <= 1'b0;
              notice_cnt_q <= '0;
              state_q      <= S_DUE;
            end
          end
        end

        S_CANCEL: begin
          res_valid_q <= 1'b1;
          kind_q      <= KIND_CANCEL;
          slot_out_q  <= slot_q;
          last_q      <= 1'b1;
          if (in_range_q && active_q[SW'(slot_q)]) begin
            was_q                 <= 1'b1;
            // Clamp a passed expiry at zero.
            rem_q                 <= diff_le0 ? '0 : diff[DELAY_W-1:0];
            active_q[SW'(slot_q)] <= 1'b0;
          end else begin
            was_q <= 1'b0;
            rem_q <= '0;
          end
          state_q <= S_IDLE;
        end

        S_DUE: begin
          if (idx_at_last) begin
            state_q <= S_DUE_END;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end

        S_DUE_END: begin
          idx_q    <= '0;
          best_v_q <= 1'b0;
          state_q  <= S_SEL;
        end

        S_SEL: begin
          if (idx_at_last) begin
            state_q <= S_SEL_END;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end

        S_SEL_END: begin
          state_q <= S_PICK;
        end

        S_PICK: begin
          if (best_v_q) begin
            // Release the previous pick, which now is known not to be the last.
            if (pend_v_q) begin
              res_valid_q <= 1'b1;
              kind_q      <= KIND_EXPIRY;
              slot_out_q  <= SLOT_W'(pend_idx_q);
              was_q       <= 1'b0;
              rem_q       <= '0;
              last_q      <= 1'b0;
            end
            pend_v_q             <= 1'b1;
            pend_idx_q           <= best_idx_q;
            notice_cnt_q         <= notice_cnt_q + 1'b1;
            due_q[best_idx_q]    <= 1'b0;
            active_q[best_idx_q] <= rearm;
            if (rearm) begin
              stamp_cnt_q <= stamp_cnt_q + 1'b1;
            end
            idx_q    <= '0;
            best_v_q <= 1'b0;
            if (notice_cnt_q == NW'(MAX_NOTICES - 1)) begin
              state_q <= S_FLUSH;
            end else begin
              state_q <= S_SEL;
            end
          end else begin
            // Nothing more is due: the held pick closes the tick.
            if (pend_v_q) begin
              res_valid_q <= 1'b1;
              kind_q      <= KIND_EXPIRY;
              slot_out_q  <= SLOT_W'(pend_idx_q);
              was_q       <= 1'b0;
              rem_q       <= '0;
              last_q      <= 1'b1;
            end
            pend_v_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end

        S_FLUSH: begin
          res_valid_q <= 1'b1;
          kind_q      <= KIND_EXPIRY;
          slot_out_q  <= SLOT_W'(pend_idx_q);
          was_q       <= 1'b0;
          rem_q       <= '0;
          last_q      <= 1'b1;
          pend_v_q    <= 1'b0;
          state_q     <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // Due pass: mark armed slots whose expiry has been reached.
      if (chk_v_q && ((state_q == S_DUE) || (state_q == S_DUE_END))) begin
        due_q[chk_idx_q] <= active_q[chk_idx_q] && diff_le0;
      end

      // Selection pass: keep the earliest expiry, ties by older stamp.
      if (chk_v_q && ((state_q == S_SEL) || (state_q == S_SEL_END))) begin
        if (due_q[chk_idx_q] && better) begin
          best_v_q      <= 1'b1;
          best_idx_q    <= chk_idx_q;
          best_diff_q   <= diff;
          best_stamp_q  <= ram_rdata.stamp;
          best_reload_q <= ram_rdata.reload;
        end
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign slot_out_o     = slot_out_q;
  assign was_active_o   = was_q;
  assign remaining_o    = rem_q;
  assign last_o         = last_q;

  // A cancel transfer is answered with a closing cancel reply registered from S_CANCEL.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (func_i == FUNC_CANCEL))
      |-> ##2 (result_valid_o && (kind_o == KIND_CANCEL) && last_o))
    else $error("cancel reply missing or malformed");

  // Results only follow a busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without preceding work");

  // Notices per tick stay within bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(notice_cnt_q) <= MAX_NOTICES)
    else $error("notice count overflow");

  // An expiry notice never carries cancel fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o == KIND_EXPIRY)) |-> (!was_active_o && (remaining_o == '0)))
    else $error("expiry notice with cancel fields");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import stq_pkg::*;

  localparam int unsigned SLOTS = 16;
  // func code with no operation behind it; the block must drop it silently
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};
  // extra clock cycles waited once every owed result is in and the block is idle
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct packed {
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic               was_active;
    logic [DELAY_W-1:0] remaining;
    logic               last;
  } notice_t;

  typedef struct {
    logic [1:0]         func;
    logic [SLOT_W-1:0]  slot;
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] reload;
    bit                 typed;
    logic               want_was;
    logic [DELAY_W-1:0] want_rem;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         func_i;
  logic [SLOT_W-1:0]  slot_i;
  logic [DELAY_W-1:0] delay_i;
  logic [DELAY_W-1:0] reload_interval_i;
  logic               result_valid_o;
  logic               kind_o;
  logic [SLOT_W-1:0]  slot_out_o;
  logic               was_active_o;
  logic [DELAY_W-1:0] remaining_o;
  logic               last_o;

  sorted_timer_queue_core #(
    .NUM_SLOTS(SLOTS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .slot_i           (slot_i),
    .delay_i          (delay_i),
    .reload_interval_i(reload_interval_i),
    .result_valid_o   (result_valid_o),
    .kind_o           (kind_o),
    .slot_out_o       (slot_out_o),
    .was_active_o     (was_active_o),
    .remaining_o      (remaining_o),
    .last_o           (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Shadow copy of the timer table, advanced once per accepted transfer.
  logic [TIME_W-1:0]  tick_now;
  logic [TIME_W-1:0]  next_stamp;
  logic [TIME_W-1:0]  slot_expiry [SLOTS];
  logic [DELAY_W-1:0] slot_reload [SLOTS];
  logic [TIME_W-1:0]  slot_stamp  [SLOTS];
  logic               slot_armed  [SLOTS];

  notice_t   step_notices[$];   // results of the transfer just predicted
  notice_t   pending_notices[$]; // results still owed by the block
  plan_row_t plan[$];
  int        mismatch_count = 0;
  int        burst_left = 0;

  // Signed view of a modulo-2^32 time difference.
  function automatic int wrap_diff(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return $signed(d);
  endfunction

  function automatic void arm_entry(int s, logic [DELAY_W-1:0] d, logic [DELAY_W-1:0] r);
    slot_expiry[s] = tick_now + {1'b0, d};
    slot_reload[s] = r;
    slot_stamp[s]  = next_stamp;
    next_stamp     = next_stamp + 1;
    slot_armed[s]  = 1'b1;
  endfunction

  // Advance the shadow table by one operation and collect what it emits.
  function automatic void timer_step(logic [1:0] f, logic [SLOT_W-1:0] s,
                                     logic [DELAY_W-1:0] d, logic [DELAY_W-1:0] r);
    notice_t n;
    bit      due [SLOTS];
    int      best;
    int      left;
    int      count;
    int      i;
    n = '0;
    case (f)
      FUNC_ARM: begin
        if (s < SLOTS) arm_entry(s, d, r);
      end
      FUNC_CANCEL: begin
        n.kind = KIND_CANCEL;
        n.slot = s;
        n.last = 1'b1;
        if (s < SLOTS && slot_armed[s]) begin
          left = wrap_diff(slot_expiry[s], tick_now);
          n.was_active = 1'b1;
          n.remaining = (left > 0) ? left[DELAY_W-1:0] : '0;
          slot_armed[s] = 1'b0;
        end
        step_notices.push_back(n);
      end
      FUNC_TICK: begin
        tick_now = tick_now + 1;
        // Freeze the due set first so a slot re-armed below cannot fire twice.
        for (i = 0; i < SLOTS; i++)
          due[i] = slot_armed[i] && (wrap_diff(slot_expiry[i], tick_now) <= 0);
        count = 0;
        while (count < MAX_NOTICES) begin
          best = -1;
          for (i = 0; i < SLOTS; i++) begin
            if (due[i]) begin
              if (best < 0) best = i;
              else if (wrap_diff(slot_expiry[i], tick_now) <
                       wrap_diff(slot_expiry[best], tick_now) ||
                       (wrap_diff(slot_expiry[i], tick_now) ==
                        wrap_diff(slot_expiry[best], tick_now) &&
                        wrap_diff(slot_stamp[i], slot_stamp[best]) < 0))
                best = i;
            end
          end
          if (best < 0) break;
          due[best] = 1'b0;
          slot_armed[best] = 1'b0;
          if (slot_reload[best] != 0) arm_entry(best, slot_reload[best], slot_reload[best]);
          n = '0;
          n.kind = KIND_EXPIRY;
          n.slot = best[SLOT_W-1:0];
          step_notices.push_back(n);
          count++;
        end
        if (count > 0) step_notices[step_notices.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void plan_add(logic [1:0] f, logic [SLOT_W-1:0] s,
                                   logic [DELAY_W-1:0] d, logic [DELAY_W-1:0] r,
                                   bit typed = 1'b0, logic want_was = 1'b0,
                                   logic [DELAY_W-1:0] want_rem = '0);
    plan_row_t row;
    row.func = f;
    row.slot = s;
    row.delay = d;
    row.reload = r;
    row.typed = typed;
    row.want_was = want_was;
    row.want_rem = want_rem;
    plan.push_back(row);
  endfunction

  // Present one item, hold it until the transfer, then log what it owes.
  // Open a new burst with a random idle gap once the current one runs out.
  task automatic issue(logic [1:0] f, logic [SLOT_W-1:0] s, logic [DELAY_W-1:0] d,
                       logic [DELAY_W-1:0] r, bit typed = 1'b0, logic want_was = 1'b0,
                       logic [DELAY_W-1:0] want_rem = '0);
    int      gap;
    notice_t n;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start             <= 1'b1;
    func_i            <= f;
    slot_i            <= s;
    delay_i           <= d;
    reload_interval_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    step_notices.delete();
    timer_step(f, s, d, r);
    if (typed) begin
      // Take the hand-written reply instead; the table still advances above.
      n = '0;
      n.kind = KIND_CANCEL;
      n.slot = s;
      n.was_active = want_was;
      n.remaining = want_rem;
      n.last = 1'b1;
      pending_notices.push_back(n);
    end else begin
      foreach (step_notices[k]) pending_notices.push_back(step_notices[k]);
    end
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every strobed result against the oldest owed one.
  notice_t rx_want;
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (pending_notices.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual slot %0d kind %0d",
                 $time, slot_out_o, kind_o);
        mismatch_count++;
      end else begin
        rx_want = pending_notices.pop_front();
        check_field("kind", 64'(rx_want.kind), 64'(kind_o));
        check_field("slot_out", 64'(rx_want.slot), 64'(slot_out_o));
        check_field("was_active", 64'(rx_want.was_active), 64'(was_active_o));
        check_field("remaining", 64'(rx_want.remaining), 64'(remaining_o));
        check_field("last", 64'(rx_want.last), 64'(last_o));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int pick;
    int sent;
    int s;
    logic [DELAY_W-1:0] d;
    logic [DELAY_W-1:0] r;

    rst_ni            = 1'b0;
    start             = 1'b0;
    func_i            = FUNC_ARM;
    slot_i            = '0;
    delay_i           = '0;
    reload_interval_i = '0;
    tick_now   = '0;
    next_stamp = '0;
    for (int i = 0; i < SLOTS; i++) slot_armed[i] = 1'b0;

    // Directed part: idle cancels at both slot ends, an empty tick, the
    // unused code, max delay, a tie on expiry, re-arming an active slot,
    // reload of one tick, zero-remaining clamp and max reload.
    plan_add(FUNC_CANCEL, 4'd0, '0, '0, 1'b1, 1'b0, '0);
    plan_add(FUNC_CANCEL, 4'd15, DELAY_MAX, DELAY_MAX, 1'b1, 1'b0, '0);
    plan_add(FUNC_TICK, 4'd0, '0, '0);
    plan_add(FUNC_UNUSED, 4'd15, DELAY_MAX, DELAY_MAX);
    plan_add(FUNC_ARM, 4'd5, DELAY_MAX, '0);
    plan_add(FUNC_CANCEL, 4'd5, '0, '0, 1'b1, 1'b1, DELAY_MAX);
    plan_add(FUNC_ARM, 4'd0, '0, '0);
    plan_add(FUNC_ARM, 4'd15, 31'd1, '0);
    plan_add(FUNC_ARM, 4'd7, 31'd1, 31'd2);
    plan_add(FUNC_TICK, 4'd0, '0, '0);
    plan_add(FUNC_ARM, 4'd4, 31'd5, '0);
    plan_add(FUNC_ARM, 4'd4, '0, 31'd1);
    plan_add(FUNC_TICK, 4'd0, '0, '0);
    plan_add(FUNC_TICK, 4'd0, '0, '0);
    plan_add(FUNC_CANCEL, 4'd4, '0, '0);
    plan_add(FUNC_CANCEL, 4'd7, '0, '0);
    plan_add(FUNC_ARM, 4'd9, '0, '0);
    plan_add(FUNC_CANCEL, 4'd9, '0, '0, 1'b1, 1'b1, '0);
    plan_add(FUNC_ARM, 4'd12, '0, DELAY_MAX);
    plan_add(FUNC_TICK, 4'd0, '0, '0);
    plan_add(FUNC_CANCEL, 4'd12, '0, '0, 1'b1, 1'b1, DELAY_MAX);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i])
      issue(plan[i].func, plan[i].slot, plan[i].delay, plan[i].reload,
            plan[i].typed, plan[i].want_was, plan[i].want_rem);

    // Random part: mostly arms with short delays and ticks so timers really
    // fire, a few full-table bursts, cancels, and some unused-code noise.
    sent = 0;
    while (sent < 220) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // Fill every slot so one tick can emit the full set of notices.
        for (s = 0; s < SLOTS; s++)
          issue(FUNC_ARM, s[SLOT_W-1:0], DELAY_W'($urandom_range(0, 2)),
                ($urandom_range(0, 2) == 0) ? DELAY_W'($urandom_range(1, 3)) : '0);
        repeat (4) issue(FUNC_TICK, SLOT_W'($urandom_range(0, 15)), DELAY_W'($urandom),
                         DELAY_W'($urandom));
        sent += SLOTS + 4;
      end else if (pick == 1) begin
        issue(FUNC_UNUSED, SLOT_W'($urandom_range(0, 15)), DELAY_W'($urandom),
              DELAY_W'($urandom));
      end else if (pick <= 8) begin
        case ($urandom_range(0, 9))
          7:       d = DELAY_W'($urandom);
          8:       d = DELAY_MAX;
          9:       d = DELAY_W'(DELAY_MAX - $urandom_range(0, 7));
          default: d = DELAY_W'($urandom_range(0, 6));
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2: r = DELAY_W'($urandom_range(1, 4));
          3:       r = DELAY_W'($urandom);
          default: r = '0;
        endcase
        issue(FUNC_ARM, SLOT_W'($urandom_range(0, 15)), d, r);
        sent++;
      end else if (pick <= 11) begin
        issue(FUNC_CANCEL, SLOT_W'($urandom_range(0, 15)), DELAY_W'($urandom),
              DELAY_W'($urandom));
        sent++;
      end else begin
        issue(FUNC_TICK, SLOT_W'($urandom_range(0, 15)), DELAY_W'($urandom),
              DELAY_W'($urandom));
        sent++;
      end
    end

    start <= 1'b0;
    while (pending_notices.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_notices.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sorted_timer_queue_core.f
rtl/core/stq_pkg.sv
rtl/core/stq_ram.sv
rtl/core/sorted_timer_queue_core.sv
tb/testbench.sv
